/* rtl/core/pbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PCI BAR decoder package
// Word types, field codes and limits shared by the decoder modules.
// ----------------------------------------------------------------------------
package pbd_pkg;

	localparam logic [7:0]  HDR_MASK       = 8'h7F;
	localparam logic [7:0]  HDR_ORDINARY   = 8'h00;
	localparam logic [7:0]  HDR_BRIDGE     = 8'h01;
	localparam logic [2:0]  LIMIT_ORDINARY = 3'd6;
	localparam logic [2:0]  LIMIT_BRIDGE   = 3'd2;
	localparam logic [2:0]  LIMIT_NONE     = 3'd0;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
	localparam logic [31:0] IO_MASK        = 32'hFFFF_FFFC;
	localparam logic [31:0] MEM_MASK       = 32'hFFFF_FFF0;
	localparam int          PREF_BIT       = 3;
	localparam logic [1:0]  TYPE_64        = 2'b10;

	localparam logic [1:0]  KIND_NONE  = 2'd0;
	localparam logic [1:0]  KIND_IO    = 2'd1;
	localparam logic [1:0]  KIND_MEM32 = 2'd2;
	localparam logic [1:0]  KIND_MEM64 = 2'd3;

	typedef struct packed {
		logic [7:0]  hdr_code;
		logic [2:0]  bar_slot;
		logic [31:0] raw_word;
	} bar_in_t;

	typedef struct packed {
		logic [2:0]  slot;
		logic        present;
		logic [1:0]  kind;
		logic        prefetchable;
		logic [63:0] base_address;
		logic [31:0] low_raw;
		logic [31:0] high_raw;
	} bar_out_t;

	typedef struct packed {
		logic        pending;
		logic [31:0] low;
		logic [2:0]  slot;
	} pair_t;

endpackage

`default_nettype wire

/* rtl/core/pbd_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PCI BAR word decode
// Decodes one registered BAR word against the pairing state: absent, I/O,
// 32-bit memory, 64-bit low half (held) or 64-bit high half.
// ----------------------------------------------------------------------------
module pbd_decode (
	input  pbd_pkg::bar_in_t  word,
	input  pbd_pkg::pair_t    pair,
	output pbd_pkg::bar_out_t result,
	output logic              emit,
	output pbd_pkg::pair_t    pair_next
);
	import pbd_pkg::*;

	logic [7:0] hdr;
	logic [2:0] limit;
	logic [3:0] slot_inc;
	logic       absent;
	logic [1:0] mtype;

	assign hdr      = word.hdr_code & HDR_MASK;
	assign slot_inc = {1'b0, word.bar_slot} + 4'd1;
	assign mtype    = word.raw_word[2:1];
	assign absent   = (word.bar_slot >= limit) || (word.raw_word == '0)
		|| (word.raw_word == ALL_ONES);

	always_comb begin
		case (hdr)
			HDR_ORDINARY: limit = LIMIT_ORDINARY;
			HDR_BRIDGE:   limit = LIMIT_BRIDGE;
			default:      limit = LIMIT_NONE;
		endcase
	end

	always_comb begin
		result              = '0;
		result.slot         = word.bar_slot;
		emit                = 1'b1;
		pair_next           = '0;
		if (pair.pending) begin
			result.slot         = pair.slot;
			result.present      = 1'b1;
			result.kind         = KIND_MEM64;
			result.prefetchable = pair.low[PREF_BIT];
			result.base_address = {word.raw_word, pair.low & MEM_MASK};
			result.low_raw      = pair.low;
			result.high_raw     = word.raw_word;
		end else if (absent) begin
			result.kind = KIND_NONE;
		end else if (word.raw_word[0]) begin
			result.present      = 1'b1;
			result.kind         = KIND_IO;
			result.base_address = {32'h0, word.raw_word & IO_MASK};
			result.low_raw      = word.raw_word;
		end else if ((mtype == TYPE_64) && (slot_inc < {1'b0, limit})) begin
			emit              = 1'b0;
			pair_next.pending = 1'b1;
			pair_next.low     = word.raw_word;
			pair_next.slot    = word.bar_slot;
		end else begin
			result.present      = 1'b1;
			result.kind         = KIND_MEM32;
			result.prefetchable = word.raw_word[PREF_BIT];
			result.base_address = {32'h0, word.raw_word & MEM_MASK};
			result.low_raw      = word.raw_word;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pci_bar_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PCI BAR decoder
// Decodes raw base address register words into typed base addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one raw BAR word with its slot and header type byte.
//   rsp channel returns one decoded word per BAR; a 64-bit memory BAR takes
//   two request words (low, then high) and returns one response word.
//   Both channels move a word on a clock edge with valid high and stall low.
// Path: the (last) request word of a BAR is taken into the input register,
//   decoded out of it and loaded into the output register, which drives the
//   response word.
// Throughput: one request word per cycle while rsp_stall is low; set by the
//   single decode stage between the input and output registers.
// Reset: arst_n clears both valid flags and the 64-bit pairing state; the
//   block takes words as soon as reset is released.
// Stall: when rsp_stall holds a response, the input register still drains a
//   held low half, then req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module pci_bar_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pbd_pkg::bar_in_t  req_word,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pbd_pkg::bar_out_t rsp_word
);
	import pbd_pkg::*;

	logic     valid_s1;
	bar_in_t  word_s1;
	pair_t    pair_q;
	pair_t    pair_next;
	bar_out_t result;
	logic     emit;
	logic     out_valid_q;
	bar_out_t out_q;
	logic     out_free;
	logic     advance;
	logic     load_s1;

	pbd_decode u_decode (
		.word      (word_s1),
		.pair      (pair_q),
		.result    (result),
		.emit      (emit),
		.pair_next (pair_next)
	);

	assign out_free  = !out_valid_q || !rsp_stall;
	assign advance   = valid_s1 && (!emit || out_free);
	assign load_s1   = !valid_s1 || advance;
	assign req_stall = !load_s1;
	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			word_s1 <= req_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (advance) begin
			pair_q <= pair_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire

/* sim/pci_bar_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCI BAR decoder test
// Sends raw BAR words, each with a slot number and a header type byte, and
// decodes each accepted word in a behavioral copy of the decoder. Checks
// every response word, field by field, against the oldest predicted word.
// Runs a directed pass over absent slots, I/O, 32-bit and 64-bit memory
// BARs, then randomized header scans with random idling on or off per channel.
// ----------------------------------------------------------------------------
module pci_bar_decoder_test;
	import pbd_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	bar_in_t  req_word = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	bar_out_t rsp_word;

	bar_out_t    expected_bars[$];
	logic        pair_held = 1'b0;
	logic [31:0] held_low = '0;
	logic [2:0]  held_slot = '0;
	int          errors = 0;
	bit          req_gaps = 1'b1;
	bit          rsp_gaps = 1'b1;

	pci_bar_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic decode_bar(input bar_in_t w);
		logic [7:0] hdr;
		logic [2:0] lim;
		bar_out_t   r;
		hdr = w.hdr_code & HDR_MASK;
		r = '0;
		if (pair_held) begin
			r.slot         = held_slot;
			r.present      = 1'b1;
			r.kind         = KIND_MEM64;
			r.prefetchable = held_low[PREF_BIT];
			r.base_address = {w.raw_word, held_low & MEM_MASK};
			r.low_raw      = held_low;
			r.high_raw     = w.raw_word;
			pair_held = 1'b0;
			held_low  = '0;
			held_slot = '0;
			expected_bars.push_back(r);
		end else begin
			if (hdr == HDR_ORDINARY)
				lim = LIMIT_ORDINARY;
			else if (hdr == HDR_BRIDGE)
				lim = LIMIT_BRIDGE;
			else
				lim = LIMIT_NONE;
			r.slot = w.bar_slot;
			if (w.bar_slot >= lim || w.raw_word == '0 || w.raw_word == ALL_ONES) begin
				expected_bars.push_back(r);
			end else if (w.raw_word[0]) begin
				r.present      = 1'b1;
				r.kind         = KIND_IO;
				r.base_address = {32'h0, w.raw_word & IO_MASK};
				r.low_raw      = w.raw_word;
				expected_bars.push_back(r);
			end else if (w.raw_word[2:1] == TYPE_64 && int'(w.bar_slot) + 1 < int'(lim)) begin
				pair_held = 1'b1;
				held_low  = w.raw_word;
				held_slot = w.bar_slot;
			end else begin
				r.present      = 1'b1;
				r.kind         = KIND_MEM32;
				r.prefetchable = w.raw_word[PREF_BIT];
				r.base_address = {32'h0, w.raw_word & MEM_MASK};
				r.low_raw      = w.raw_word;
				expected_bars.push_back(r);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		bar_out_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_bars.size() == 0) begin
					$display("%0t: response expected none actual %h", $time, rsp_word);
					errors++;
				end else begin
					e = expected_bars.pop_front();
					check_field("slot", 64'(e.slot), 64'(rsp_word.slot));
					check_field("present", 64'(e.present), 64'(rsp_word.present));
					check_field("kind", 64'(e.kind), 64'(rsp_word.kind));
					check_field("prefetchable", 64'(e.prefetchable),
						64'(rsp_word.prefetchable));
					check_field("base_address", e.base_address, rsp_word.base_address);
					check_field("low_raw", 64'(e.low_raw), 64'(rsp_word.low_raw));
					check_field("high_raw", 64'(e.high_raw), 64'(rsp_word.high_raw));
				end
			end
			if (req_valid && !req_stall)
				decode_bar(req_word);
		end
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (rsp_gaps && arst_n) begin
				n = pick_gap();
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(negedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send_bar(input logic [7:0] hdr, input logic [2:0] slot,
			input logic [31:0] raw);
		int n;
		n = req_gaps ? pick_gap() : 0;
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= '{hdr_code: hdr, bar_slot: slot, raw_word: raw};
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		wait (expected_bars.size() == 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic test_absent();
		send_bar(8'h00, 3'd0, 32'h0000_0000);
		send_bar(8'h00, 3'd1, ALL_ONES);
		send_bar(8'h00, 3'd6, 32'h1000_0000);
		send_bar(8'h00, 3'd7, 32'h0000_2001);
		send_bar(8'h02, 3'd0, 32'h1000_0000);
		send_bar(8'hFF, 3'd3, 32'h0000_C001);
		send_bar(8'h01, 3'd2, 32'hE000_0000);
	endtask

	task automatic test_io();
		send_bar(8'h00, 3'd0, 32'hFFFF_FFFD);
		send_bar(8'h80, 3'd5, 32'h0000_0001);
		send_bar(8'h01, 3'd1, 32'h0000_E003);
	endtask

	task automatic test_mem32();
		send_bar(8'h00, 3'd0, 32'hFFFF_FFF0);
		send_bar(8'h00, 3'd1, 32'hF000_0008);
		send_bar(8'h00, 3'd2, 32'h8000_0002);
		send_bar(8'h00, 3'd3, 32'h8000_000E);
		send_bar(8'h00, 3'd5, 32'hFFFF_FFF4);
		send_bar(8'h81, 3'd1, 32'h4000_000C);
	endtask

	task automatic test_mem64();
		send_bar(8'h00, 3'd0, 32'h0000_000C);
		send_bar(8'h00, 3'd1, ALL_ONES);
		send_bar(8'h00, 3'd4, 32'hFFFF_FFF4);
		send_bar(8'h55, 3'd7, 32'h0000_0000);
		send_bar(8'h01, 3'd0, 32'h8000_0004);
		send_bar(8'h01, 3'd1, 32'h0000_0001);
	endtask

	task automatic test_random_headers(input int count, input bit req_idle,
			input bit rsp_idle);
		int          sent;
		int          r;
		int          lim;
		int          last;
		int          s;
		logic [7:0]  hdr;
		logic [31:0] raw;
		req_gaps = req_idle;
		rsp_gaps = rsp_idle;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_bar(8'($urandom), 3'($urandom), $urandom);
				sent++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					hdr = {1'($urandom), 7'h00};
				else if (r < 85)
					hdr = {1'($urandom), 7'h01};
				else
					hdr = 8'($urandom);
				lim = (hdr & HDR_MASK) == HDR_ORDINARY ? 6 :
					((hdr & HDR_MASK) == HDR_BRIDGE ? 2 : 0);
				last = (lim == 0 || $urandom_range(0, 99) < 15) ?
					$urandom_range(0, 7) : lim - 1;
				s = 0;
				while (s <= last) begin
					r = $urandom_range(0, 99);
					raw = $urandom;
					if (r < 8) begin
						raw = '0;
					end else if (r < 14) begin
						raw = ALL_ONES;
					end else if (r < 35) begin
						raw[0] = 1'b1;
					end else begin
						raw[0] = 1'b0;
						raw[2:1] = ($urandom_range(0, 99) < 45) ? TYPE_64 : 2'($urandom);
					end
					send_bar(hdr, 3'(s), raw);
					sent++;
					if (raw != '0 && !raw[0] && raw[2:1] == TYPE_64 && s + 1 < lim &&
							$urandom_range(0, 99) < 85) begin
						r = $urandom_range(0, 99);
						raw = (r < 5) ? '0 : ((r < 10) ? ALL_ONES : $urandom);
						s++;
						send_bar(hdr, 3'(s), raw);
						sent++;
					end
					s++;
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_absent();
		test_io();
		test_mem32();
		test_mem64();
		drain();
		test_random_headers(600, 1'b1, 1'b1);
		test_random_headers(300, 1'b0, 1'b0);
		drain();
		test_random_headers(300, 1'b1, 1'b0);
		test_random_headers(300, 1'b0, 1'b1);
		drain();
		test_random_headers(350, 1'b1, 1'b1);
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
